FILE: rtl/lcdr_pkg.sv
// ----------------------------------------------------------------------------
// lcdr_pkg
// Shared types and constants for the dirty-tracked serial LCD refresh block.
// ----------------------------------------------------------------------------
package lcdr_pkg;

  // input operation codes
  localparam logic OP_SET     = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  // serial link sync bytes and display commands
  localparam logic [7:0] SYNC_CMD    = 8'hF8;
  localparam logic [7:0] SYNC_DATA   = 8'hFA;
  localparam logic [7:0] CMD_GDRAM   = 8'h80;
  localparam logic [7:0] CMD_EXT_GFX = 8'h26;
  localparam logic [7:0] NIBBLE_HI   = 8'hF0;

  // refresh job handed from the front to the back; sized for the largest grid
  typedef struct packed {
    logic       need_mode;  // send the extended graphic mode switch first
    logic [1:0] grp;        // column group (eight pixels wide)
    logic [4:0] row;        // pixel row
    logic [7:0] data;       // pixel byte snapshot
  } job_t;

endpackage

FILE: rtl/dirty_tracked_lcd_refresh.sv
// A set-pixel item holds the input through the accept, store read and write-back states.
// A refresh item scans the dirty marks 8 per cycle,
// then reads the byte and queues the job, waiting while the job queue is full.
// The serializer then sends 24 bytes (27 with the mode switch), one per cycle at most;
// the serializer and the LCD link's stall set the sustained rate.
// Reset (synchronous, rst_n low): dirty marks, written marks and mode flag clear at once.
// ----------------------------------------------------------------------------
// dirty_tracked_lcd_refresh
// Top level: pixel store with dirty tracking, job queue and frame serializer.
// ----------------------------------------------------------------------------
module dirty_tracked_lcd_refresh #(
  parameter int GRID_SIDE = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [7:0] in_pixel_x,
  input  logic [7:0] in_pixel_y,
  input  logic       in_pixel_on,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_lcd_byte,
  output logic       out_last_of_run
);
  import lcdr_pkg::*;

  logic push_valid;
  job_t push_job;
  logic push_full;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  lcdr_front #(
    .GRID_SIDE(GRID_SIDE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .in_pixel_x  (in_pixel_x),
    .in_pixel_y  (in_pixel_y),
    .in_pixel_on (in_pixel_on),
    .push_valid  (push_valid),
    .push_job    (push_job),
    .push_full   (push_full)
  );

  lcdr_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_job  (push_job),
    .push_full (push_full),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job)
  );

  lcdr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_job        (pop_job),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lcd_byte   (out_lcd_byte),
    .out_last_of_run(out_last_of_run)
  );

endmodule

FILE: rtl/lcdr_ram.sv
// ----------------------------------------------------------------------------
// lcdr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lcdr_fifo.sv
// ----------------------------------------------------------------------------
// lcdr_fifo
// Two-entry job queue between the classifier front and the serializer back.
// ----------------------------------------------------------------------------
module lcdr_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  lcdr_pkg::job_t push_job,
  output logic           push_full,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lcdr_pkg::job_t pop_job
);
  import lcdr_pkg::*;

  job_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_full = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_job   = entry_r[rd_ptr_r];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/lcdr_front.sv
// ----------------------------------------------------------------------------
// lcdr_front
// Accepts items, updates the pixel store and dirty marks, and turns refresh
// items into jobs for the serializer.
// ----------------------------------------------------------------------------
module lcdr_front #(
  parameter int GRID_SIDE = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_operation,
  input  logic [7:0]     in_pixel_x,
  input  logic [7:0]     in_pixel_y,
  input  logic           in_pixel_on,
  output logic           push_valid,
  output lcdr_pkg::job_t push_job,
  input  logic           push_full
);
  import lcdr_pkg::*;

  localparam int ROW_W   = $clog2(GRID_SIDE);
  localparam int GROUPS  = (GRID_SIDE + 7) / 8;
  localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int ADDR_W  = GRP_W + ROW_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int CHUNKS  = DEPTH / 8;
  localparam int CHUNK_W = ADDR_W - 3;
  localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNKS - 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SET_RD  = 6'b000010,
    S_SET_WR  = 6'b000100,
    S_SCAN    = 6'b001000,
    S_SCAN_RD = 6'b010000,
    S_PUSH    = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [7:0]          mask_r, mask_nxt;
  logic                on_r, on_nxt;
  logic [CHUNK_W-1:0]  chunk_r, chunk_nxt;
  logic                ext_r, ext_nxt;
  logic [DEPTH-1:0]    dirty_r, dirty_nxt;
  logic [DEPTH-1:0]    written_r, written_nxt;

  logic [7:0]          chunk_bits;
  logic                chunk_hit;
  logic [2:0]          first_pos;
  logic [7:0]          rd_data;
  logic [7:0]          old_byte;
  logic [7:0]          new_byte;
  logic                in_range;
  logic                ram_re;
  logic                ram_we;

  assign in_stall = (state_r != S_IDLE);
  assign in_range = (in_pixel_x < 8'(GRID_SIDE)) && (in_pixel_y < 8'(GRID_SIDE));

  // bytes never written read as zero
  assign old_byte = written_r[addr_r] ? rd_data : 8'h00;
  assign new_byte = on_r ? (old_byte | mask_r) : (old_byte & ~mask_r);

  assign chunk_bits = dirty_r[{chunk_r, 3'b000} +: 8];
  assign chunk_hit  = |chunk_bits;

  always_comb begin
    first_pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (chunk_bits[i]) begin
        first_pos = 3'(i);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    mask_nxt    = mask_r;
    on_nxt      = on_r;
    chunk_nxt   = chunk_r;
    ext_nxt     = ext_r;
    dirty_nxt   = dirty_r;
    written_nxt = written_r;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    push_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_SET) begin
            if (in_range) begin
              addr_nxt  = {in_pixel_x[3 +: GRP_W], in_pixel_y[ROW_W-1:0]};
              mask_nxt  = 8'h80 >> in_pixel_x[2:0];
              on_nxt    = in_pixel_on;
              state_nxt = S_SET_RD;
            end
          end else begin
            chunk_nxt = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SET_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SET_WR;
      end
      S_SET_WR: begin
        // only a real change marks the byte dirty
        if (new_byte != old_byte) begin
          ram_we              = 1'b1;
          written_nxt[addr_r] = 1'b1;
          dirty_nxt[addr_r]   = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (chunk_hit) begin
          addr_nxt  = {chunk_r, first_pos};
          state_nxt = S_SCAN_RD;
        end else if (chunk_r == CHUNK_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      S_SCAN_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!push_full) begin
          push_valid        = 1'b1;
          dirty_nxt[addr_r] = 1'b0;
          ext_nxt           = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    push_job.need_mode = !ext_r;
    push_job.grp       = 2'(addr_r[ADDR_W-1 -: GRP_W]);
    push_job.row       = 5'(addr_r[ROW_W-1:0]);
    push_job.data      = old_byte;
  end

  lcdr_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_r),
    .wdata(new_byte),
    .re   (ram_re),
    .raddr(addr_r),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      chunk_r   <= '0;
      ext_r     <= 1'b0;
      dirty_r   <= '0;
      written_r <= '0;
    end else begin
      state_r   <= state_nxt;
      chunk_r   <= chunk_nxt;
      ext_r     <= ext_nxt;
      dirty_r   <= dirty_nxt;
      written_r <= written_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    mask_r <= mask_nxt;
    on_r   <= on_nxt;
  end

endmodule

FILE: rtl/lcdr_back.sv
// ----------------------------------------------------------------------------
// lcdr_back
// Serializer: expands one refresh job into three-byte LCD frames, one byte
// per cycle while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module lcdr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  lcdr_pkg::job_t pop_job,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_lcd_byte,
  output logic           out_last_of_run
);
  import lcdr_pkg::*;

  // frame 0 is the mode switch, frames 1..8 cover two display rows
  localparam logic [3:0] FRAME_MODE  = 4'd0;
  localparam logic [3:0] FRAME_FIRST = 4'd1;
  localparam logic [3:0] FRAME_LAST  = 4'd8;

  localparam logic [1:0] BYTE_SYNC = 2'd0;
  localparam logic [1:0] BYTE_HI   = 2'd1;
  localparam logic [1:0] BYTE_LO   = 2'd2;

  localparam logic [1:0] KIND_VADDR   = 2'd0;
  localparam logic [1:0] KIND_HADDR   = 2'd1;
  localparam logic [1:0] KIND_DATA_HI = 2'd2;
  localparam logic [1:0] KIND_DATA_LO = 2'd3;

  function automatic logic [7:0] widen(input logic [3:0] n);
    logic [7:0] w;
    for (int i = 0; i < 4; i++) begin
      w[2*i +: 2] = {2{n[i]}};
    end
    return w;
  endfunction

  logic       busy_r, busy_nxt;
  job_t       job_r, job_nxt;
  logic [3:0] frame_r, frame_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic [3:0] fidx;
  logic [1:0] kind;
  logic [5:0] disp_row;
  logic [7:0] payload;
  logic [7:0] sync;
  logic [7:0] cur_byte;
  logic       is_last;
  logic       load;

  assign pop_ready = !busy_r;
  assign load      = busy_r && (!out_valid_r || !out_stall);

  assign fidx     = frame_r - FRAME_FIRST;
  assign kind     = fidx[1:0];
  assign disp_row = {job_r.row, fidx[2]};
  assign is_last  = (frame_r == FRAME_LAST) && (sub_r == BYTE_LO);

  always_comb begin
    if (frame_r == FRAME_MODE) begin
      payload = CMD_EXT_GFX;
      sync    = SYNC_CMD;
    end else begin
      case (kind)
        KIND_VADDR: begin
          payload = CMD_GDRAM | {3'b000, disp_row[4:0]};
          sync    = SYNC_CMD;
        end
        KIND_HADDR: begin
          // bit 3 selects the lower screen half
          payload = CMD_GDRAM | {4'b0000, disp_row[5], 1'b0, job_r.grp};
          sync    = SYNC_CMD;
        end
        KIND_DATA_HI: begin
          payload = widen(job_r.data[7:4]);
          sync    = SYNC_DATA;
        end
        KIND_DATA_LO: begin
          payload = widen(job_r.data[3:0]);
          sync    = SYNC_DATA;
        end
        default: begin
          payload = 8'h00;
          sync    = SYNC_CMD;
        end
      endcase
    end
    case (sub_r)
      BYTE_SYNC: cur_byte = sync;
      BYTE_HI:   cur_byte = payload & NIBBLE_HI;
      BYTE_LO:   cur_byte = {payload[3:0], 4'b0000};
      default:   cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    job_nxt       = job_r;
    frame_nxt     = frame_r;
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (!busy_r) begin
      if (pop_valid) begin
        busy_nxt  = 1'b1;
        job_nxt   = pop_job;
        frame_nxt = pop_job.need_mode ? FRAME_MODE : FRAME_FIRST;
        sub_nxt   = BYTE_SYNC;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_nxt = 1'b0;
      end
    end else if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = is_last;
      if (sub_r == BYTE_LO) begin
        sub_nxt = BYTE_SYNC;
        if (frame_r == FRAME_LAST) begin
          busy_nxt = 1'b0;
        end else begin
          frame_nxt = frame_r + 4'd1;
        end
      end else begin
        sub_nxt = sub_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      frame_r     <= FRAME_MODE;
      sub_r       <= BYTE_SYNC;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      frame_r     <= frame_nxt;
      sub_r       <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_lcd_byte    = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

FILE: rtl/lcdr_check.sv
// ----------------------------------------------------------------------------
// lcdr_check
// Port-level checks on the LCD byte stream: handshake and frame structure.
// ----------------------------------------------------------------------------
module lcdr_check (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_lcd_byte,
  input logic       out_last_of_run
);
  import lcdr_pkg::*;

  // byte position inside the current three-byte frame
  logic [1:0] pos_r;
  logic       xfer;

  assign xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
    end else if (xfer) begin
      pos_r <= (pos_r == 2'd2) ? 2'd0 : pos_r + 2'd1;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_lcd_byte) && $stable(out_last_of_run))
    else $error("output payload changed while stalled");

  a_sync_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pos_r == 2'd0 |-> out_lcd_byte == SYNC_CMD || out_lcd_byte == SYNC_DATA)
    else $error("frame does not open with a sync byte");

  a_nibble_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pos_r != 2'd0 |-> out_lcd_byte[3:0] == 4'h0)
    else $error("frame nibble byte has low bits set");

  a_last_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> pos_r == 2'd2)
    else $error("run ends inside a frame");

endmodule

bind dirty_tracked_lcd_refresh lcdr_check u_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_lcd_byte   (out_lcd_byte),
  .out_last_of_run(out_last_of_run)
);

FILE: test/tb_dirty_tracked_lcd_refresh.sv
// ----------------------------------------------------------------------------
// tb_dirty_tracked_lcd_refresh
// Drives set-pixel and refresh items into the block and checks the serial
// LCD byte stream. A scoreboard tracks its own copy of the pixel store,
// dirty marks and mode flag, and predicts the frames for each refresh.
// Both sides idle at random, and at one point the receiver holds off for a
// long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module tb_dirty_tracked_lcd_refresh;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdr_pkg::*;

  localparam int GRID_SIDE    = 32;
  localparam int GROUPS       = (GRID_SIDE + 7) / 8;
  localparam int STORE_BYTES  = GROUPS * GRID_SIDE;
  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 47;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       last_of_run;
  } lcd_xfer_t;

  class lcd_scoreboard;
    logic [7:0] pixels [STORE_BYTES];
    bit         dirty  [STORE_BYTES];
    bit         gfx_mode;
    lcd_xfer_t  frames_due [$];
    int         fail_count;

    function new();
      foreach (pixels[i]) begin
        pixels[i] = 8'h00;
        dirty[i]  = 1'b0;
      end
      gfx_mode   = 1'b0;
      fail_count = 0;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // each pixel of the nibble becomes two adjacent bits
    function logic [7:0] double_width(logic [3:0] n);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 4; i++) r[2*i +: 2] = {2{n[i]}};
      return r;
    endfunction

    // sync byte, high nibble, low nibble moved up
    function void queue_frame(logic [7:0] sync, logic [7:0] payload);
      lcd_xfer_t t;
      t.last_of_run = 1'b0;
      t.lcd_byte = sync;
      frames_due.push_back(t);
      t.lcd_byte = payload & NIBBLE_HI;
      frames_due.push_back(t);
      t.lcd_byte = {payload[3:0], 4'h0};
      frames_due.push_back(t);
    endfunction

    function void note_input(logic op, logic [7:0] x, logic [7:0] y, logic on);
      int         idx;
      int         grp;
      int         row;
      logic [7:0] mask;
      logic [7:0] nv;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [5:0] r;
      lcd_xfer_t  t;
      if (op == OP_SET) begin
        if (x >= GRID_SIDE || y >= GRID_SIDE) return;
        idx  = (x / 8) * GRID_SIDE + y;
        mask = 8'h80 >> x[2:0];
        nv   = on ? (pixels[idx] | mask) : (pixels[idx] & ~mask);
        if (nv != pixels[idx]) begin
          pixels[idx] = nv;
          dirty[idx]  = 1'b1;
        end
      end else begin
        idx = -1;
        for (int i = 0; i < STORE_BYTES; i++) begin
          if (dirty[i]) begin
            idx = i;
            break;
          end
        end
        if (idx < 0) return;
        dirty[idx] = 1'b0;
        grp = idx / GRID_SIDE;
        row = idx % GRID_SIDE;
        hi  = double_width(pixels[idx][7:4]);
        lo  = double_width(pixels[idx][3:0]);
        if (!gfx_mode) begin
          queue_frame(SYNC_CMD, CMD_EXT_GFX);
          gfx_mode = 1'b1;
        end
        for (int k = 0; k < 2; k++) begin
          r = 6'(row * 2 + k);
          queue_frame(SYNC_CMD, CMD_GDRAM | {3'b000, r[4:0]});
          queue_frame(SYNC_CMD, CMD_GDRAM | {4'h0, r[5], 3'(grp)});
          queue_frame(SYNC_DATA, hi);
          queue_frame(SYNC_DATA, lo);
        end
        t = frames_due.pop_back();
        t.last_of_run = 1'b1;
        frames_due.push_back(t);
      end
    endfunction

    function void check_result(logic [7:0] b, logic last);
      lcd_xfer_t want;
      if (frames_due.size() == 0) begin
        $error("unexpected transfer: lcd_byte %h last_of_run %b", b, last);
        fail_count++;
        return;
      end
      want = frames_due.pop_front();
      if (b !== want.lcd_byte) begin
        $error("lcd_byte: expected %h, actual %h", want.lcd_byte, b);
        fail_count++;
      end
      if (last !== want.last_of_run) begin
        $error("last_of_run: expected %b, actual %b", want.last_of_run, last);
        fail_count++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_operation;
  logic [7:0] in_pixel_x;
  logic [7:0] in_pixel_y;
  logic       in_pixel_on;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_lcd_byte;
  logic       out_last_of_run;

  lcd_scoreboard sb;
  bit            tx_quiet;
  bit            rx_quiet;
  bit            rx_hold_req;
  int            cycle_count;

  dirty_tracked_lcd_refresh #(
    .GRID_SIDE(GRID_SIDE)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_pixel_on    (in_pixel_on),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lcd_byte   (out_lcd_byte),
    .out_last_of_run(out_last_of_run)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // one input transfer; valid stays up across back-to-back items
  task automatic send_item(logic op, logic [7:0] x, logic [7:0] y, logic on);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_pixel_x   <= x;
    in_pixel_y   <= y;
    in_pixel_on  <= on;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, x, y, on);
  endtask

  // mostly in-range pixel writes and refreshes, some off-grid writes
  task automatic run_random(int count, int refresh_pct);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < refresh_pct)
        send_item(OP_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom));
      else if (sel < refresh_pct + 10)
        send_item(OP_SET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom));
      else
        send_item(OP_SET, 8'($urandom_range(0, GRID_SIDE - 1)),
                  8'($urandom_range(0, GRID_SIDE - 1)), 1'($urandom));
    end
  endtask

  // LCD side: random stall per transfer, plus one long hold on request
  initial begin : lcd_sink
    int n;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      n = rx_quiet ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_lcd_byte, out_last_of_run);
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    sb          = new();
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    rx_hold_req = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_SET;
    in_pixel_x   <= 8'h00;
    in_pixel_y   <= 8'h00;
    in_pixel_on  <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty refresh, corners, off-grid, unchanged bits
    send_item(OP_REFRESH, 8'd0, 8'd0, 1'b0);
    send_item(OP_SET, 8'd0, 8'd0, 1'b1);
    send_item(OP_SET, 8'd0, 8'd0, 1'b1);
    send_item(OP_SET, 8'd31, 8'd31, 1'b1);
    send_item(OP_SET, 8'd32, 8'd0, 1'b1);
    send_item(OP_SET, 8'd0, 8'd32, 1'b1);
    send_item(OP_SET, 8'd255, 8'd255, 1'b1);
    send_item(OP_REFRESH, 8'd0, 8'd0, 1'b0);    // first refresh carries mode switch
    send_item(OP_REFRESH, 8'd0, 8'd0, 1'b0);    // bottom-right byte, lower half rows
    send_item(OP_REFRESH, 8'd0, 8'd0, 1'b0);
    send_item(OP_SET, 8'd7, 8'd5, 1'b1);
    send_item(OP_SET, 8'd0, 8'd5, 1'b1);
    send_item(OP_SET, 8'd7, 8'd5, 1'b0);
    send_item(OP_SET, 8'd3, 8'd3, 1'b1);
    send_item(OP_SET, 8'd3, 8'd3, 1'b0);        // back to zero but still dirty
    send_item(OP_SET, 8'd8, 8'd10, 1'b1);
    send_item(OP_SET, 8'd15, 8'd10, 1'b1);
    send_item(OP_SET, 8'd20, 8'd20, 1'b0);      // already clear
    send_item(OP_REFRESH, 8'd255, 8'd255, 1'b1);
    send_item(OP_REFRESH, 8'd0, 8'd0, 1'b0);
    send_item(OP_REFRESH, 8'd0, 8'd0, 1'b0);
    send_item(OP_REFRESH, 8'd0, 8'd0, 1'b0);

    run_random(PHASE_ITEMS, 25);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    run_random(PHASE_ITEMS, 30);
    rx_quiet    = 1'b0;
    rx_hold_req = 1'b1;
    run_random(PHASE_ITEMS, 40);
    tx_quiet = 1'b0;
    run_random(PHASE_ITEMS, 25);

    // drop valid right at the last transfer so it is not taken twice
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/lcdr_pkg.sv
rtl/lcdr_ram.sv
rtl/lcdr_fifo.sv
rtl/lcdr_front.sv
rtl/lcdr_back.sv
rtl/dirty_tracked_lcd_refresh.sv
rtl/lcdr_check.sv
test/tb_dirty_tracked_lcd_refresh.sv
